// ===== hw/rtl/jpeg_huffman_decode_table_builder_defines.svh =====
// Assertion macros shared by the table builder RTL.
`ifndef JPEG_HUFFMAN_DECODE_TABLE_BUILDER_DEFINES_SVH
`define JPEG_HUFFMAN_DECODE_TABLE_BUILDER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define JHDTB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define JHDTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/jhdtb_pkg.sv =====
// Shared types and constants of the Huffman table builder.
package jhdtb_pkg;

  localparam int DEF_MAX_TABLES = 8;
  localparam int QDEPTH         = 2;

  localparam logic [11:0] AC_LIMIT   = 12'h100;
  localparam logic [11:0] DC_LIMIT   = 12'h010;
  localparam logic [15:0] EMPTY_LAST = 16'hFFFF;
  localparam logic [3:0]  LAST_LEN   = 4'd15;

  localparam logic KIND_ENTRY = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  // One parsed table handed from the parser to the entry generator.
  // counts[0] holds the count of length 16, counts[15] that of length 1.
  typedef struct packed {
    logic             bad;
    logic [2:0]       tbl;
    logic             ac;
    logic [11:0]      total;
    logic [15:0][7:0] counts;
  } job_t;

endpackage

// ===== hw/rtl/jhdtb_front.sv =====
// Segment byte parser: class byte, sixteen counts, symbol skip, table check.
module jhdtb_front #(
  parameter int MAX_TABLES = jhdtb_pkg::DEF_MAX_TABLES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [3:0]        cfg_table_count,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic              in_segment_start,
  output logic              q_push,
  output jhdtb_pkg::job_t   q_job,
  input  logic              q_full
);
  import jhdtb_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_COUNTS,
    PH_SYMBOLS,
    PH_CLASS
  } phase_t;

  localparam logic [3:0] MaxTables = 4'(MAX_TABLES);

  phase_t           phase_r;
  logic [3:0]       tc_r;
  logic [2:0]       tn_r;
  logic [3:0]       li_r;
  logic [11:0]      total_r;
  logic             class_r;
  logic [8:0]       sl_r;
  logic             halted_r;
  logic [15:0][7:0] cnt_r;

  logic [3:0]  eff_tables;
  logic        last_table;
  logic        in_fire;
  logic        at_last_count;
  logic [11:0] total_sum;
  logic [8:0]  sl_dec;
  logic        bad;

  // Clamp the configured table count
  always_comb begin
    if (tc_r == 4'd0) begin
      eff_tables = 4'd1;
    end else if (tc_r > MaxTables) begin
      eff_tables = MaxTables;
    end else begin
      eff_tables = tc_r;
    end
  end

  assign last_table = (({1'b0, tn_r} + 4'd1) >= eff_tables);

  // Stall only when the sixteenth count would meet a full queue
  assign at_last_count = (phase_r == PH_COUNTS) && (li_r == LAST_LEN) && !halted_r;
  assign in_ready      = !q_full || !at_last_count;
  assign in_fire       = in_valid && in_ready;

  assign total_sum = total_r + 12'(in_data_byte);
  assign sl_dec    = (sl_r != 9'd0) ? (sl_r - 9'd1) : 9'd0;
  assign bad       = (total_sum == 12'd0) ||
                     (class_r && (total_sum > AC_LIMIT)) ||
                     (!class_r && (total_sum > DC_LIMIT));

  // Build the job word for the queue
  assign q_push       = in_fire && !in_segment_start && at_last_count;
  assign q_job.bad    = bad;
  assign q_job.tbl    = tn_r;
  assign q_job.ac     = class_r;
  assign q_job.total  = total_sum;
  assign q_job.counts = {cnt_r[14:0], in_data_byte};

  // Shift in count bytes
  always_ff @(posedge clk) begin
    if (in_fire && !in_segment_start && !halted_r && (phase_r == PH_COUNTS)) begin
      cnt_r <= {cnt_r[14:0], in_data_byte};
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      tc_r     <= 4'd1;
      tn_r     <= 3'd0;
      li_r     <= 4'd0;
      total_r  <= 12'd0;
      class_r  <= 1'b0;
      sl_r     <= 9'd0;
      halted_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        tc_r <= cfg_table_count;
      end
      if (in_fire) begin
        if (in_segment_start) begin
          halted_r <= 1'b0;
          tn_r     <= 3'd0;
          class_r  <= |in_data_byte[7:4];
          li_r     <= 4'd0;
          total_r  <= 12'd0;
          phase_r  <= PH_COUNTS;
        end else if (!halted_r) begin
          unique case (phase_r)
            PH_CLASS: begin
              class_r <= |in_data_byte[7:4];
              li_r    <= 4'd0;
              total_r <= 12'd0;
              phase_r <= PH_COUNTS;
            end
            PH_SYMBOLS: begin
              sl_r <= sl_dec;
              if (sl_dec == 9'd0) begin
                if (last_table) begin
                  phase_r <= PH_IDLE;
                end else begin
                  tn_r    <= tn_r + 3'd1;
                  phase_r <= PH_CLASS;
                end
              end
            end
            PH_COUNTS: begin
              total_r <= total_sum;
              if (li_r != LAST_LEN) begin
                li_r <= li_r + 4'd1;
              end else begin
                li_r <= 4'd0;
                if (bad) begin
                  halted_r <= 1'b1;
                  phase_r  <= PH_IDLE;
                end else begin
                  sl_r    <= total_sum[8:0];
                  phase_r <= PH_SYMBOLS;
                end
              end
            end
            PH_IDLE: begin
              phase_r <= PH_IDLE;
            end
            default: begin
              phase_r <= PH_IDLE;
            end
          endcase
        end
      end
    end
  end

endmodule

// ===== hw/rtl/jhdtb_fifo.sv =====
// Short job queue between the parser and the entry generator.
`include "jpeg_huffman_decode_table_builder_defines.svh"
module jhdtb_fifo #(
  parameter int DEPTH = jhdtb_pkg::QDEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  jhdtb_pkg::job_t push_job,
  output logic            full,
  input  logic            pop,
  output jhdtb_pkg::job_t head,
  output logic            empty
);
  import jhdtb_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [AW-1:0] wp_r;
  logic [AW-1:0] rp_r;
  logic [CW-1:0] cnt_r;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  `JHDTB_ASSERT_NOW(a_no_push_full, push, !full || pop, "push into full job queue")
  `JHDTB_ASSERT_NOW(a_no_pop_empty, pop, !empty, "pop from empty job queue")

endmodule

// ===== hw/rtl/jhdtb_back.sv =====
// Entry generator: sixteen length words per job, or one error word if bad.
`include "jpeg_huffman_decode_table_builder_defines.svh"
module jhdtb_back (
  input  logic            clk,
  input  logic            rst_n,
  input  jhdtb_pkg::job_t job,
  input  logic            q_empty,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_result_kind,
  output logic [2:0]      out_table_index,
  output logic            out_is_ac_table,
  output logic [4:0]      out_code_length,
  output logic [15:0]     out_first_code,
  output logic [15:0]     out_last_code,
  output logic [7:0]      out_value_offset,
  output logic [11:0]     out_total_codes,
  output logic            out_last_of_run
);
  import jhdtb_pkg::*;

  logic [3:0]  len_r;
  logic [15:0] code_r;
  logic [7:0]  off_r;

  logic        out_valid_r;
  logic        kind_r;
  logic [2:0]  tbl_r;
  logic        ac_r;
  logic [4:0]  clen_r;
  logic [15:0] first_r;
  logic [15:0] last_r;
  logic [7:0]  voff_r;
  logic [11:0] total_r;
  logic        lor_r;

  logic        load;
  logic [7:0]  n;
  logic        nonempty;
  logic [15:0] code_sum;
  logic        last_len;

  assign load     = !out_valid_r || out_ready;
  assign n        = job.counts[~len_r];
  assign nonempty = (n != 8'd0);
  assign code_sum = code_r + 16'(n);
  assign last_len = (len_r == LAST_LEN);
  assign q_pop    = load && !q_empty && (job.bad || last_len);

  // Step through lengths and fill the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      len_r       <= 4'd0;
      code_r      <= 16'd0;
      off_r       <= 8'd0;
    end else if (load) begin
      out_valid_r <= !q_empty;
      if (!q_empty) begin
        if (job.bad || last_len) begin
          len_r  <= 4'd0;
          code_r <= 16'd0;
          off_r  <= 8'd0;
        end else begin
          len_r  <= len_r + 4'd1;
          code_r <= nonempty ? {code_sum[14:0], 1'b0} : {code_r[14:0], 1'b0};
          off_r  <= off_r + n;
        end
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      tbl_r   <= job.tbl;
      ac_r    <= job.ac;
      total_r <= job.total;
      if (job.bad) begin
        kind_r  <= KIND_ERROR;
        clen_r  <= 5'd0;
        first_r <= 16'd0;
        last_r  <= 16'd0;
        voff_r  <= 8'd0;
        lor_r   <= 1'b1;
      end else begin
        kind_r  <= KIND_ENTRY;
        clen_r  <= {1'b0, len_r} + 5'd1;
        first_r <= nonempty ? code_r : 16'd0;
        last_r  <= nonempty ? (code_sum - 16'd1) : EMPTY_LAST;
        voff_r  <= nonempty ? off_r : 8'd0;
        lor_r   <= last_len;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = kind_r;
  assign out_table_index  = tbl_r;
  assign out_is_ac_table  = ac_r;
  assign out_code_length  = clen_r;
  assign out_first_code   = first_r;
  assign out_last_code    = last_r;
  assign out_value_offset = voff_r;
  assign out_total_codes  = total_r;
  assign out_last_of_run  = lor_r;

  `JHDTB_ASSERT_NEXT(a_pop_ends_run, q_pop, out_valid_r && lor_r, "job retired without run end")
  `JHDTB_ASSERT_NOW(a_run_has_job, len_r != 4'd0, !q_empty, "length walk without a queued job")

endmodule

// ===== hw/rtl/jpeg_huffman_decode_table_builder.sv =====
// With an idle queue, the first entry passes through the job queue and the output register.
// Throughput: one segment byte per cycle; a valid table yields sixteen entries, one a cycle
// while out_ready is high, from the entry generator; the input stalls only while two parsed
// tables wait in the queue. An invalid table yields a single error word, after which bytes
// are dropped until the next segment start. Reset (rst_n low, synchronous) empties the queue
// and output register, returns the parser to idle and sets the table count register to 1.
module jpeg_huffman_decode_table_builder #(
  parameter int MAX_TABLES = jhdtb_pkg::DEF_MAX_TABLES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_table_count,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_segment_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [2:0]  out_table_index,
  output logic        out_is_ac_table,
  output logic [4:0]  out_code_length,
  output logic [15:0] out_first_code,
  output logic [15:0] out_last_code,
  output logic [7:0]  out_value_offset,
  output logic [11:0] out_total_codes,
  output logic        out_last_of_run
);
  import jhdtb_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  job_t push_job;
  job_t head_job;

  assign cfg_ready = 1'b1;

  jhdtb_front #(
    .MAX_TABLES (MAX_TABLES)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_table_count  (cfg_table_count),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_segment_start (in_segment_start),
    .q_push           (q_push),
    .q_job            (push_job),
    .q_full           (q_full)
  );

  jhdtb_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .head     (head_job),
    .empty    (q_empty)
  );

  jhdtb_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .job              (head_job),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_table_index  (out_table_index),
    .out_is_ac_table  (out_is_ac_table),
    .out_code_length  (out_code_length),
    .out_first_code   (out_first_code),
    .out_last_code    (out_last_code),
    .out_value_offset (out_value_offset),
    .out_total_codes  (out_total_codes),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

// ===== verif/jpeg_huffman_decode_table_builder_test.sv =====
// Self-checking testbench for the JPEG DHT Huffman decode table builder.
`timescale 1ns / 1ps

module jpeg_huffman_decode_table_builder_test;
  import jhdtb_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 10;
  localparam int BODY_ITEMS     = 330;
  localparam int MIN_SETTINGS   = 4;
  localparam int SETTLE_CYCLES  = 24;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_GAP        = 11;
  localparam int REPORT_LIMIT   = 10;
  localparam int FULL_PILE      = 200;

  typedef enum logic [1:0] {
    PARSE_IDLE,
    PARSE_COUNTS,
    PARSE_SYMBOLS,
    PARSE_CLASS
  } parse_phase_t;

  typedef enum int {
    SHAPE_VALID,
    SHAPE_WIDE,
    SHAPE_FULL,
    SHAPE_ZERO,
    SHAPE_OVER,
    SHAPE_OVER_BY_ONE,
    SHAPE_CUT
  } table_shape_t;

  typedef struct {
    logic        kind;
    logic [2:0]  tbl;
    logic        ac;
    logic [4:0]  len;
    logic [15:0] first_code;
    logic [15:0] last_code;
    logic [7:0]  offset;
    logic [11:0] total;
    logic        run_end;
  } huff_word_t;

  typedef struct {
    logic [7:0] data;
    logic       start;
  } body_byte_t;

  // Canonical table predictor and store of the entries still to come.
  class huff_entry_checker;
    logic [3:0]   table_count;
    parse_phase_t phase;
    logic [2:0]   tbl_num;
    logic [3:0]   len_idx;
    logic [7:0]   counts [16];
    logic [11:0]  total;
    logic         ac;
    logic [8:0]   symbols_left;
    logic         halted;
    huff_word_t   entries_due [$];
    int           mismatches;
    int           entries_seen;
    int           errors_seen;

    function new();
      table_count  = 4'd1;
      phase        = PARSE_IDLE;
      tbl_num      = 3'd0;
      len_idx      = 4'd0;
      total        = 12'd0;
      ac           = 1'b0;
      symbols_left = 9'd0;
      halted       = 1'b0;
      foreach (counts[i]) counts[i] = 8'd0;
      mismatches   = 0;
      entries_seen = 0;
      errors_seen  = 0;
    endfunction

    function void set_table_count(logic [3:0] value);
      table_count = value;
    endfunction

    function int pending();
      return entries_due.size();
    endfunction

    // Start a table on its class byte.
    function void open_table(logic [7:0] cls);
      ac      = (cls[7:4] != 4'd0);
      len_idx = 4'd0;
      total   = 12'd0;
      phase   = PARSE_COUNTS;
    endfunction

    // Advance to the next table, or go idle after the last one.
    function void close_table();
      int tables_due;
      tables_due = (table_count == 4'd0) ? 1 :
                   (table_count > DEF_MAX_TABLES) ? DEF_MAX_TABLES : int'(table_count);
      if (int'(tbl_num) + 1 >= tables_due) begin
        phase = PARSE_IDLE;
      end else begin
        tbl_num = tbl_num + 3'd1;
        phase   = PARSE_CLASS;
      end
    endfunction

    // Predict what one accepted byte causes; return 0 when the byte is dropped.
    function bit note_byte(logic [7:0] data, logic start);
      huff_word_t  w;
      logic [15:0] code;
      logic [7:0]  offset;
      bit          bad;
      if (start) begin
        halted  = 1'b0;
        tbl_num = 3'd0;
        open_table(data);
        return 1'b1;
      end
      if (halted) return 1'b0;
      case (phase)
        PARSE_CLASS: begin
          open_table(data);
          return 1'b1;
        end
        PARSE_SYMBOLS: begin
          if (symbols_left != 9'd0) symbols_left = symbols_left - 9'd1;
          if (symbols_left == 9'd0) close_table();
          return 1'b1;
        end
        PARSE_COUNTS: begin
          counts[len_idx] = data;
          total = total + 12'(data);
          if (len_idx != LAST_LEN) begin
            len_idx = len_idx + 4'd1;
            return 1'b1;
          end
          len_idx = 4'd0;
          bad = (total == 12'd0) || (ac && total > AC_LIMIT) || (!ac && total > DC_LIMIT);
          w.tbl   = tbl_num;
          w.ac    = ac;
          w.total = total;
          // Emit one error word and drop bytes until the next segment.
          if (bad) begin
            w.kind       = KIND_ERROR;
            w.len        = 5'd0;
            w.first_code = 16'd0;
            w.last_code  = 16'd0;
            w.offset     = 8'd0;
            w.run_end    = 1'b1;
            entries_due.push_back(w);
            halted = 1'b1;
            phase  = PARSE_IDLE;
            return 1'b1;
          end
          // Walk the lengths, assigning canonical codes that wrap at 16 bits.
          code   = 16'd0;
          offset = 8'd0;
          for (int i = 0; i < 16; i++) begin
            w.kind    = KIND_ENTRY;
            w.len     = 5'(i + 1);
            w.run_end = (i == 15);
            if (counts[i] != 8'd0) begin
              w.first_code = code;
              w.last_code  = code + 16'(counts[i]) - 16'd1;
              w.offset     = offset;
              code   = code + 16'(counts[i]);
              offset = offset + counts[i];
            end else begin
              w.first_code = 16'd0;
              w.last_code  = EMPTY_LAST;
              w.offset     = 8'd0;
            end
            code = code << 1;
            entries_due.push_back(w);
          end
          symbols_left = total[8:0];
          phase = PARSE_SYMBOLS;
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    function string show(huff_word_t w);
      return {$sformatf("kind=%0d tbl=%0d ac=%0d len=%0d ", w.kind, w.tbl, w.ac, w.len),
              $sformatf("first=%h last=%h off=%0d total=%0d end=%0d", w.first_code,
                        w.last_code, w.offset, w.total, w.run_end)};
    endfunction

    function void flag(string what, bit have_want, huff_word_t want, huff_word_t got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("%0t: %s\n  expected %s\n  actual   %s", $time, what,
                 have_want ? show(want) : "(nothing)", show(got));
      end
    endfunction

    // Compare one output word with the oldest expected entry.
    function void check_word(huff_word_t got);
      huff_word_t want;
      if (got.kind == KIND_ERROR) errors_seen++;
      else entries_seen++;
      if (entries_due.size() == 0) begin
        flag("output word with nothing expected", 1'b0, got, got);
        return;
      end
      want = entries_due.pop_front();
      if (got.kind !== want.kind || got.tbl !== want.tbl || got.ac !== want.ac ||
          got.len !== want.len || got.first_code !== want.first_code ||
          got.last_code !== want.last_code || got.offset !== want.offset ||
          got.total !== want.total || got.run_end !== want.run_end) begin
        flag("output word mismatch", 1'b1, want, got);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_table_count = 4'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_segment_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_result_kind;
  logic [2:0]  out_table_index;
  logic        out_is_ac_table;
  logic [4:0]  out_code_length;
  logic [15:0] out_first_code;
  logic [15:0] out_last_code;
  logic [7:0]  out_value_offset;
  logic [11:0] out_total_codes;
  logic        out_last_of_run;

  huff_entry_checker sb;
  body_byte_t        segment_bytes [$];
  bit                hold_request = 1'b0;
  int                bytes_sent = 0;
  int                parsed_bytes = 0;
  int                dropped_bytes = 0;
  int                settings_done = 0;
  int                in_burst_left = 0;
  bit                in_steady = 1'b0;

  jpeg_huffman_decode_table_builder #(
    .MAX_TABLES(DEF_MAX_TABLES)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_table_count  (cfg_table_count),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_segment_start (in_segment_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_table_index  (out_table_index),
    .out_is_ac_table  (out_is_ac_table),
    .out_code_length  (out_code_length),
    .out_first_code   (out_first_code),
    .out_last_code    (out_last_code),
    .out_value_offset (out_value_offset),
    .out_total_codes  (out_total_codes),
    .out_last_of_run  (out_last_of_run)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Draw the sender gap; some stretches run with no idling at all.
  function automatic int next_in_gap();
    if (in_burst_left == 0) begin
      in_steady     = ($urandom_range(0, 3) == 0);
      in_burst_left = $urandom_range(8, 40);
    end
    in_burst_left--;
    return in_steady ? 0 : int'($urandom_range(0, MAX_GAP));
  endfunction

  function automatic void push_body(logic [7:0] data, logic start);
    body_byte_t b;
    b.data  = data;
    b.start = start;
    segment_bytes.push_back(b);
  endfunction

  // Spread a total over the sixteen lengths, or pile it onto one length.
  function automatic void spread_counts(int total, bit pile, output logic [7:0] counts [16]);
    int pick;
    foreach (counts[i]) counts[i] = 8'd0;
    if (pile && total <= 255) begin
      pick = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 3) : $urandom_range(0, 15);
      counts[pick] = 8'(total);
      return;
    end
    repeat (total) begin
      pick = $urandom_range(0, 15);
      while (counts[pick] == 8'hFF) pick = (pick + 1) % 16;
      counts[pick] = counts[pick] + 8'd1;
    end
  endfunction

  // Build one segment body: mostly well-formed tables, some broken ones.
  function automatic void build_segment(int tables_due, bit full_ac, bit all_good);
    logic [7:0]   counts [16];
    logic [7:0]   cls;
    table_shape_t shape;
    bit           ac;
    int           total;
    int           pick;
    int           table_head;
    int           keep;
    for (int t = 0; t < tables_due; t++) begin
      ac = ($urandom_range(0, 1) == 1);
      case ($urandom_range(0, 19)) inside
        0:       shape = SHAPE_ZERO;
        1:       shape = SHAPE_OVER;
        2:       shape = SHAPE_OVER_BY_ONE;
        3:       shape = SHAPE_CUT;
        [4:5]:   shape = SHAPE_WIDE;
        default: shape = SHAPE_VALID;
      endcase
      // Keep every table of a pressure segment well formed.
      if (all_good && shape != SHAPE_WIDE) shape = SHAPE_VALID;
      if (full_ac && t == 0) begin
        ac    = 1'b1;
        shape = SHAPE_FULL;
      end
      cls = ac ? {4'($urandom_range(1, 15)), 4'($urandom)} : {4'd0, 4'($urandom)};
      case (shape)
        SHAPE_ZERO: begin
          foreach (counts[i]) counts[i] = 8'd0;
        end
        SHAPE_OVER: begin
          foreach (counts[i]) counts[i] = 8'($urandom);
          counts[0]  = 8'hFF;
          counts[15] = 8'hFF;
        end
        SHAPE_OVER_BY_ONE: begin
          spread_counts(ac ? int'(AC_LIMIT) + 1 : int'(DC_LIMIT) + 1, 1'b0, counts);
        end
        SHAPE_WIDE: begin
          spread_counts(ac ? int'($urandom_range(9, 40)) : int'(DC_LIMIT),
                        ($urandom_range(0, 1) == 1), counts);
        end
        SHAPE_FULL: begin
          // Reach the AC limit exactly, with one heavy length.
          spread_counts(int'(AC_LIMIT) - FULL_PILE, 1'b0, counts);
          pick = $urandom_range(0, 15);
          while (counts[pick] > 8'(255 - FULL_PILE)) pick = (pick + 1) % 16;
          counts[pick] = counts[pick] + 8'(FULL_PILE);
        end
        default: begin
          spread_counts($urandom_range(1, 8), ($urandom_range(0, 3) == 0), counts);
        end
      endcase
      table_head = segment_bytes.size();
      total = 0;
      push_body(cls, (t == 0));
      foreach (counts[i]) begin
        push_body(counts[i], 1'b0);
        total += counts[i];
      end
      // Follow a bad table with bytes the block must drop.
      if (shape == SHAPE_ZERO || shape == SHAPE_OVER || shape == SHAPE_OVER_BY_ONE) begin
        repeat ($urandom_range(1, 3)) push_body(8'($urandom), 1'b0);
        return;
      end
      // Leave the full table early in its symbols; the next segment start takes over.
      if (shape == SHAPE_FULL) begin
        repeat ($urandom_range(1, 16)) push_body(8'($urandom), 1'b0);
        return;
      end
      repeat (total) push_body(8'($urandom), 1'b0);
      // Abandon the table part way; the next segment start takes over.
      if (shape == SHAPE_CUT) begin
        keep = $urandom_range(1, segment_bytes.size() - table_head - 1);
        while (segment_bytes.size() > table_head + keep) void'(segment_bytes.pop_back());
        return;
      end
    end
    // Trail a few bytes onto the idle parser.
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 2)) push_body(8'($urandom), 1'b0);
    end
  endfunction

  // Offer one byte, hold it until accepted, then note it.
  task automatic send_byte(body_byte_t item, bit rush);
    int gap;
    gap = rush ? 0 : next_in_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_data_byte     <= item.data;
    in_segment_start <= item.start;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (sb.note_byte(item.data, item.start)) parsed_bytes++;
    else dropped_bytes++;
  endtask

  // Drop the input, drain all results and let in-flight bytes settle.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_table_count(logic [3:0] value);
    cfg_valid       <= 1'b1;
    cfg_table_count <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_table_count(value);
  endtask

  // Check every accepted output word.
  always @(posedge clk) begin : result_monitor
    huff_word_t got;
    if (rst_n && out_valid && out_ready) begin
      got.kind       = out_result_kind;
      got.tbl        = out_table_index;
      got.ac         = out_is_ac_table;
      got.len        = out_code_length;
      got.first_code = out_first_code;
      got.last_code  = out_last_code;
      got.offset     = out_value_offset;
      got.total      = out_total_codes;
      got.run_end    = out_last_of_run;
      sb.check_word(got);
    end
  end

  // Stall the output at random, with one long hold-off on request.
  initial begin : result_sink
    int wait_cycles;
    int burst_left;
    bit steady;
    bit held;
    burst_left = 0;
    steady     = 1'b0;
    held       = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (burst_left == 0) begin
        steady     = ($urandom_range(0, 3) == 0);
        burst_left = $urandom_range(8, 40);
      end
      burst_left--;
      wait_cycles = steady ? 0 : $urandom_range(0, MAX_GAP);
      if (hold_request && !held) begin
        wait_cycles = LONG_HOLD;
        held        = 1'b1;
      end
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // End the run when no word moves on any channel for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : main_flow
    body_byte_t b;
    logic [3:0] setting;
    int         tables_due;
    int         segments;
    bit         rush;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Bytes ahead of any segment start are dropped.
    b.start = 1'b0;
    b.data  = 8'hFF;
    send_byte(b, 1'b0);
    b.data  = 8'h00;
    send_byte(b, 1'b0);
    // A DC table with no codes at all fails, then bytes are dropped.
    b.start = 1'b1;
    send_byte(b, 1'b0);
    b.start = 1'b0;
    repeat (16) send_byte(b, 1'b0);
    b.data = 8'hA5;
    send_byte(b, 1'b0);
    b.data = 8'h5A;
    send_byte(b, 1'b0);

    // Run segment bodies under a sequence of table-count settings.
    while (bytes_sent < BODY_ITEMS || settings_done < MIN_SETTINGS) begin
      case (settings_done)
        0:       setting = 4'd0;
        1:       setting = 4'd1;
        2:       setting = 4'd8;
        3:       setting = 4'd15;
        default: setting = 4'($urandom_range(0, 15));
      endcase
      settle_block();
      write_table_count(setting);
      tables_due = (setting == 4'd0) ? 1 :
                   (setting > DEF_MAX_TABLES) ? DEF_MAX_TABLES : int'(setting);
      rush = (settings_done == 2);
      if (rush) hold_request = 1'b1;
      segments = (settings_done < MIN_SETTINGS) ? 1 : $urandom_range(1, 2);
      for (int s = 0; s < segments; s++) begin
        segment_bytes.delete();
        build_segment(tables_due, (settings_done == 1 && s == 0), rush);
        foreach (segment_bytes[i]) send_byte(segment_bytes[i], rush);
      end
      settings_done++;
    end

    settle_block();
    $display("covered %0d body bytes (%0d parsed, %0d dropped) under %0d table-count settings",
             bytes_sent, parsed_bytes, dropped_bytes, settings_done);
    $display("checked %0d table entries and %0d error words, %0d mismatches, %0d left over",
             sb.entries_seen, sb.errors_seen, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/jhdtb_pkg.sv
hw/rtl/jhdtb_front.sv
hw/rtl/jhdtb_fifo.sv
hw/rtl/jhdtb_back.sv
hw/rtl/jpeg_huffman_decode_table_builder.sv
verif/jpeg_huffman_decode_table_builder_test.sv
